// ----- src/spc_pkg.sv -----
`default_nettype none

package spc_pkg;

  // Signal numbering and widths
  localparam int SIGNAL_COUNT = 64;
  localparam int SIG_IDX_W    = $clog2(SIGNAL_COUNT);
  localparam int SIG_NUM_W    = 7;
  localparam int PEND_W       = 64;

  localparam logic [PEND_W-1:0] VALID_MASK = (SIGNAL_COUNT >= PEND_W) ? {PEND_W{1'b1}} :
      ((PEND_W'(1) << SIGNAL_COUNT) - PEND_W'(1));

  localparam logic [SIG_NUM_W-1:0] MAX_SIG = SIG_NUM_W'(SIGNAL_COUNT);

  localparam logic [SIG_NUM_W-1:0] SIGKILL = 7'd9;
  localparam logic [SIG_NUM_W-1:0] SIGCONT = 7'd18;
  localparam logic [SIG_NUM_W-1:0] SIGSTOP = 7'd19;
  localparam logic [SIG_NUM_W-1:0] SIGTSTP = 7'd20;
  localparam logic [SIG_NUM_W-1:0] SIGTTIN = 7'd21;
  localparam logic [SIG_NUM_W-1:0] SIGTTOU = 7'd22;

  // Handler kinds held in the action table
  localparam logic [1:0] H_DEFAULT = 2'd0;
  localparam logic [1:0] H_IGNORE  = 2'd1;
  localparam logic [1:0] H_CAUGHT  = 2'd2;

  typedef enum logic [2:0] {
    OP_SEND         = 3'd0,
    OP_POP          = 3'd1,
    OP_SET_BLOCKED  = 3'd2,
    OP_SET_ACTION   = 3'd3,
    OP_READ_PENDING = 3'd4
  } op_t;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_DELIVER = 3'd1;
  localparam logic [2:0] ACT_TERM    = 3'd2;
  localparam logic [2:0] ACT_CORE    = 3'd3;
  localparam logic [2:0] ACT_STOP    = 3'd4;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_INVALID = 1'b1;

  localparam logic REG_IS_INIT = 1'b0;

  typedef enum logic [2:0] {
    D_TERM,
    D_IGN,
    D_CORE,
    D_STOP,
    D_CONT
  } disp_t;

  typedef struct packed {
    logic       reset_flag;
    logic [1:0] kind;
  } entry_t;

  typedef struct packed {
    logic                 we;
    logic [SIG_IDX_W-1:0] waddr;
    entry_t               wdata;
    logic [SIG_IDX_W-1:0] raddr;
  } ram_req_t;

  function automatic logic [PEND_W-1:0] sig_bit(input logic [SIG_NUM_W-1:0] s);
    logic [5:0] sh;
    sh = 6'(s - 7'd1);
    return PEND_W'(1) << sh;
  endfunction

  function automatic disp_t default_disp(input logic [SIG_NUM_W-1:0] s);
    disp_t d;
    case (s)
      7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd11, 7'd24, 7'd25, 7'd31: d = D_CORE;
      7'd17, 7'd23, 7'd28:                   d = D_IGN;
      SIGSTOP, SIGTSTP, SIGTTIN, SIGTTOU:    d = D_STOP;
      SIGCONT:                               d = D_CONT;
      default:                               d = D_TERM;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- src/spc_action_ram.sv -----
`default_nettype none

module spc_action_ram
  import spc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  ram_req_t req,
  output entry_t   rdata
);

  entry_t                  mem [SIGNAL_COUNT];
  logic [SIGNAL_COUNT-1:0] written;
  entry_t                  rraw;
  logic                    rvalid;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rraw <= mem[req.raddr];
  end

  // Unwritten entries read as the default handler with no reset flag
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rvalid  <= 1'b0;
    end else begin
      if (req.we) begin
        written[req.waddr] <= 1'b1;
      end
      rvalid <= written[req.raddr];
    end
  end

  assign rdata = rvalid ? rraw : '0;

endmodule

`default_nettype wire

// ----- src/spc_lowest_bit.sv -----
`default_nettype none

module spc_lowest_bit
  import spc_pkg::*;
(
  input  logic [PEND_W-1:0]    word,
  output logic                 found,
  output logic [SIG_IDX_W-1:0] index,
  output logic [PEND_W-1:0]    onehot
);

  // Isolate the lowest set bit, then encode it
  assign onehot = word & (~word + PEND_W'(1));
  assign found  = |word;

  always_comb begin
    index = '0;
    for (int i = 0; i < SIGNAL_COUNT; i++) begin
      if (onehot[i]) begin
        index = index | SIG_IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/signal_pending_controller_core.sv -----
`default_nettype none

// Channel   Ports                                              Transfer when
// -------   -------------------------------------------------  --------------------------
// command   start, busy, operation, signal_number, to_group,   start && !busy
//           new_blocked_mask, handler_kind, reset_on_delivery
// result    done, status, popped_signal, pop_action,           done (one cycle, no stall)
//           pending_set
// config    psel, penable, pwrite, paddr, pwdata, prdata,      psel && penable && pwrite
//           pready
//
// Set blocked, set action, read pending and rejected commands report from the
// execute state; send first waits in a further state for the action table read.
// A pop returns from a wait state to the execute state for each pending signal
// that it skips, and ends when it acts on one or when none is left visible.
// Each signal examined costs a pass through the lowest-bit finder and a
// registered table read.
// Synchronous reset clears pending sets, blocked mask, table valid bits and
// is_init_process. The receiver cannot stall: done pulses for one cycle.

module signal_pending_controller_core
  import spc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // command
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           operation,
  input  logic [SIG_NUM_W-1:0] signal_number,
  input  logic                 to_group,
  input  logic [PEND_W-1:0]    new_blocked_mask,
  input  logic [1:0]           handler_kind,
  input  logic                 reset_on_delivery,
  // result
  output logic                 done,
  output logic                 status,
  output logic [SIG_NUM_W-1:0] popped_signal,
  output logic [2:0]           pop_action,
  output logic [PEND_W-1:0]    pending_set,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEND_WAIT,
    S_POP_WAIT
  } state_t;

  state_t state;

  // Captured command
  logic [2:0]           op_q;
  logic [SIG_NUM_W-1:0] sig_q;
  logic                 grp_q;
  logic [PEND_W-1:0]    mask_q;
  logic [1:0]           kind_q;
  logic                 rod_q;

  // Architectural state
  logic [PEND_W-1:0]    private_pending;
  logic [PEND_W-1:0]    group_pending;
  logic [PEND_W-1:0]    blocked_mask;
  logic                 is_init_process;
  logic [SIG_IDX_W-1:0] pop_idx;

  logic [PEND_W-1:0]    private_next;
  logic [PEND_W-1:0]    group_next;
  logic [PEND_W-1:0]    visible;
  logic                 low_found;
  logic [SIG_IDX_W-1:0] low_idx;
  logic [PEND_W-1:0]    low_bit;
  logic                 sig_in_range;
  logic                 action_ok;
  logic [1:0]           kind_norm;
  logic [SIG_NUM_W-1:0] pop_sig;
  disp_t                send_disp;
  disp_t                pop_disp;
  ram_req_t             ram_req;
  entry_t               ram_rdata;
  logic                 cfg_write;

  // ---------------------------------------------------------------------
  // Configuration port: one register, is_init_process, at byte address 0
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      is_init_process <= 1'b0;
    end else if (cfg_write && (paddr[2] == REG_IS_INIT)) begin
      is_init_process <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_IS_INIT) ? {31'd0, is_init_process} : 32'd0;

  // ---------------------------------------------------------------------
  // Lowest-bit finder over the visible pending word, used by pop
  // ---------------------------------------------------------------------
  assign visible = (private_pending | group_pending) & ~blocked_mask & VALID_MASK;

  spc_lowest_bit u_lowest (
    .word   (visible),
    .found  (low_found),
    .index  (low_idx),
    .onehot (low_bit)
  );

  // ---------------------------------------------------------------------
  // Action table
  // ---------------------------------------------------------------------
  spc_action_ram u_table (
    .clk   (clk),
    .rst   (rst),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign sig_in_range = (sig_q != '0) && (sig_q <= MAX_SIG);
  assign action_ok    = sig_in_range && (sig_q != SIGKILL) && (sig_q != SIGSTOP);
  assign kind_norm    = (kind_q == 2'd3) ? H_DEFAULT : kind_q;
  assign pop_sig      = SIG_NUM_W'(pop_idx) + 7'd1;
  assign send_disp    = default_disp(sig_q);
  assign pop_disp     = default_disp(pop_sig);

  always_comb begin
    ram_req       = '0;
    // Send reads its own entry, pop reads the lowest visible one
    ram_req.raddr = (op_q == OP_SEND) ? SIG_IDX_W'(sig_q - 7'd1) : low_idx;
    if ((state == S_EXEC) && (op_q == OP_SET_ACTION) && action_ok) begin
      ram_req.we               = 1'b1;
      ram_req.waddr            = SIG_IDX_W'(sig_q - 7'd1);
      ram_req.wdata.kind       = kind_norm;
      ram_req.wdata.reset_flag = rod_q;
    end else if ((state == S_POP_WAIT) && (ram_rdata.kind == H_CAUGHT) &&
                 ram_rdata.reset_flag) begin
      // Revert a one-shot handler to default; keep the flag
      ram_req.we               = 1'b1;
      ram_req.waddr            = pop_idx;
      ram_req.wdata.kind       = H_DEFAULT;
      ram_req.wdata.reset_flag = 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Send update: stop/continue clearing first, then the drop check
  // ---------------------------------------------------------------------
  always_comb begin
    logic [PEND_W-1:0] clr;
    logic [PEND_W-1:0] b;
    logic              drop;
    b   = sig_bit(sig_q);
    clr = '0;
    if (send_disp == D_CONT) begin
      clr = sig_bit(SIGSTOP) | sig_bit(SIGTSTP) | sig_bit(SIGTTIN) | sig_bit(SIGTTOU);
    end else if (send_disp == D_STOP) begin
      clr = sig_bit(SIGCONT);
    end
    drop = 1'b0;
    if ((blocked_mask & b) == '0) begin
      drop = (is_init_process && (ram_rdata.kind == H_DEFAULT)) ||
             (ram_rdata.kind == H_IGNORE) ||
             ((ram_rdata.kind == H_DEFAULT) && (send_disp == D_IGN));
    end
    private_next = private_pending & ~clr;
    group_next   = group_pending & ~clr;
    if (!drop) begin
      if (grp_q) begin
        group_next = group_next | b;
      end else begin
        private_next = private_next | b;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      done            <= 1'b0;
      private_pending <= '0;
      group_pending   <= '0;
      blocked_mask    <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q          <= operation;
            sig_q         <= signal_number;
            grp_q         <= to_group;
            mask_q        <= new_blocked_mask;
            kind_q        <= handler_kind;
            rod_q         <= reset_on_delivery;
            // Fields that do not belong to the operation report zero
            status        <= ST_OK;
            popped_signal <= '0;
            pop_action    <= ACT_NONE;
            pending_set   <= '0;
            state         <= S_EXEC;
          end
        end

        S_EXEC: begin
          unique case (op_q)
            OP_SEND: begin
              if (sig_q > MAX_SIG) begin
                status <= ST_INVALID;
                done   <= 1'b1;
                state  <= S_IDLE;
              end else if (sig_q == '0) begin
                // Existence probe: no effect
                done  <= 1'b1;
                state <= S_IDLE;
              end else begin
                state <= S_SEND_WAIT;
              end
            end
            OP_POP: begin
              if (!low_found) begin
                done  <= 1'b1;
                state <= S_IDLE;
              end else begin
                private_pending <= private_pending & ~low_bit;
                group_pending   <= group_pending & ~low_bit;
                pop_idx         <= low_idx;
                state           <= S_POP_WAIT;
              end
            end
            OP_SET_BLOCKED: begin
              // Kill and stop can never be blocked
              blocked_mask <= mask_q & VALID_MASK & ~(sig_bit(SIGKILL) | sig_bit(SIGSTOP));
              done         <= 1'b1;
              state        <= S_IDLE;
            end
            OP_SET_ACTION: begin
              if (!action_ok) begin
                status <= ST_INVALID;
              end
              done  <= 1'b1;
              state <= S_IDLE;
            end
            OP_READ_PENDING: begin
              pending_set <= visible;
              done        <= 1'b1;
              state       <= S_IDLE;
            end
            default: begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          endcase
        end

        S_SEND_WAIT: begin
          private_pending <= private_next;
          group_pending   <= group_next;
          done            <= 1'b1;
          state           <= S_IDLE;
        end

        S_POP_WAIT: begin
          if (ram_rdata.kind == H_IGNORE) begin
            state <= S_EXEC;
          end else if (ram_rdata.kind == H_CAUGHT) begin
            popped_signal <= pop_sig;
            pop_action    <= ACT_DELIVER;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            unique case (pop_disp)
              D_TERM: begin
                popped_signal <= pop_sig;
                pop_action    <= ACT_TERM;
                done          <= 1'b1;
                state         <= S_IDLE;
              end
              D_CORE: begin
                popped_signal <= pop_sig;
                pop_action    <= ACT_CORE;
                done          <= 1'b1;
                state         <= S_IDLE;
              end
              D_STOP: begin
                popped_signal <= pop_sig;
                pop_action    <= ACT_STOP;
                done          <= 1'b1;
                state         <= S_IDLE;
              end
              default: begin
                // Ignore or continue by default: skip and look again
                state <= S_EXEC;
              end
            endcase
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not make the block busy");

  a_kill_stop_unblocked: assert property (@(posedge clk) disable iff (rst)
    $past(state == S_EXEC && op_q == OP_SET_BLOCKED) |->
      (!blocked_mask[SIG_IDX_W'(SIGKILL - 7'd1)] && !blocked_mask[SIG_IDX_W'(SIGSTOP - 7'd1)]))
    else $error("kill or stop became blocked");

  a_action_has_signal: assert property (@(posedge clk) disable iff (rst)
    (done && (pop_action != ACT_NONE)) |-> (popped_signal != '0))
    else $error("pop action reported without a signal");

endmodule

`default_nettype wire

// ----- test/spc_outcome_checker.sv -----
`default_nettype none

module spc_outcome_checker
  import spc_pkg::*;
#(
  parameter logic [2:0] INIT_ADDR = 3'd0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [2:0]           operation,
  input  logic [SIG_NUM_W-1:0] signal_number,
  input  logic                 to_group,
  input  logic [PEND_W-1:0]    new_blocked_mask,
  input  logic [1:0]           handler_kind,
  input  logic                 reset_on_delivery,
  input  logic                 done,
  input  logic                 status,
  input  logic [SIG_NUM_W-1:0] popped_signal,
  input  logic [2:0]           pop_action,
  input  logic [PEND_W-1:0]    pending_set,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  input  logic                 pready,
  output int                   error_count,
  output int                   awaited_count,
  output int                   checked_count,
  output int                   acted_pop_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                 status;
    logic [SIG_NUM_W-1:0] sig;
    logic [2:0]           act;
    logic [PEND_W-1:0]    pset;
  } outcome_t;

  // Shadow copy of the task's signal state
  logic              init_proc;
  logic [PEND_W-1:0] thread_pend;
  logic [PEND_W-1:0] group_pend;
  logic [PEND_W-1:0] block_mask;
  logic [1:0]        hkind  [SIGNAL_COUNT];
  logic              hreset [SIGNAL_COUNT];
  outcome_t          awaited_outcomes [$];

  function automatic logic [PEND_W-1:0] bit_of(input int unsigned s);
    return PEND_W'(1) << (s - 1);
  endfunction

  function automatic disp_t default_fate(input int unsigned s);
    if (s inside {3, 4, 5, 6, 7, 8, 11, 24, 25, 31}) return D_CORE;
    if (s inside {17, 23, 28}) return D_IGN;
    if (s == SIGCONT) return D_CONT;
    if (s >= SIGSTOP && s <= SIGTTOU) return D_STOP;
    return D_TERM;
  endfunction

  function automatic logic [PEND_W-1:0] visible_pending();
    return (thread_pend | group_pend) & ~block_mask & VALID_MASK;
  endfunction

  task automatic record_send(input int unsigned s, input logic grp);
    disp_t             fate;
    logic [PEND_W-1:0] wipe;
    fate = default_fate(s);
    wipe = '0;
    if (fate == D_CONT) begin
      wipe = bit_of(SIGSTOP) | bit_of(SIGTSTP) | bit_of(SIGTTIN) | bit_of(SIGTTOU);
    end else if (fate == D_STOP) begin
      wipe = bit_of(SIGCONT);
    end
    thread_pend &= ~wipe;
    group_pend  &= ~wipe;
    // drop unblocked signals that would be discarded on arrival
    if (!block_mask[s-1]) begin
      if (hkind[s-1] == H_IGNORE) return;
      if (hkind[s-1] == H_DEFAULT && (init_proc || fate == D_IGN)) return;
    end
    if (grp) group_pend |= bit_of(s);
    else thread_pend |= bit_of(s);
  endtask

  task automatic take_signal(output logic [SIG_NUM_W-1:0] sig, output logic [2:0] act);
    logic [PEND_W-1:0] ready;
    logic              settled;
    int unsigned       s;
    int                i;
    disp_t             fate;
    sig = '0;
    act = ACT_NONE;
    settled = 1'b0;
    repeat (PEND_W) begin
      if (!settled) begin
        ready = visible_pending();
        if (ready == '0) begin
          settled = 1'b1;
        end else begin
          s = 0;
          for (i = PEND_W - 1; i >= 0; i--) if (ready[i]) s = i + 1;
          thread_pend[s-1] = 1'b0;
          group_pend[s-1]  = 1'b0;
          if (hkind[s-1] == H_CAUGHT) begin
            if (hreset[s-1]) hkind[s-1] = H_DEFAULT;
            sig = SIG_NUM_W'(s);
            act = ACT_DELIVER;
            settled = 1'b1;
          end else if (hkind[s-1] != H_IGNORE) begin
            fate = default_fate(s);
            case (fate)
              D_TERM:  act = ACT_TERM;
              D_CORE:  act = ACT_CORE;
              D_STOP:  act = ACT_STOP;
              default: act = ACT_NONE;
            endcase
            if (act != ACT_NONE) begin
              sig = SIG_NUM_W'(s);
              settled = 1'b1;
            end
          end
        end
      end
    end
  endtask

  task automatic predict_command();
    outcome_t             o;
    int unsigned          s;
    logic [SIG_NUM_W-1:0] psig;
    logic [2:0]           pact;
    o = '0;
    s = signal_number;
    case (operation)
      OP_SEND: begin
        if (s > SIGNAL_COUNT) o.status = ST_INVALID;
        else if (s != 0) record_send(s, to_group);
      end
      OP_POP: begin
        take_signal(psig, pact);
        o.sig = psig;
        o.act = pact;
      end
      OP_SET_BLOCKED: begin
        block_mask = new_blocked_mask & VALID_MASK & ~(bit_of(SIGKILL) | bit_of(SIGSTOP));
      end
      OP_SET_ACTION: begin
        if (s == 0 || s > SIGNAL_COUNT || s == SIGKILL || s == SIGSTOP) begin
          o.status = ST_INVALID;
        end else begin
          hkind[s-1] = (handler_kind inside {H_DEFAULT, H_IGNORE, H_CAUGHT}) ?
                       handler_kind : H_DEFAULT;
          hreset[s-1] = reset_on_delivery;
        end
      end
      OP_READ_PENDING: o.pset = visible_pending();
      default: ;
    endcase
    awaited_outcomes.push_back(o);
  endtask

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      init_proc   = 1'b0;
      thread_pend = '0;
      group_pend  = '0;
      block_mask  = '0;
      for (int k = 0; k < SIGNAL_COUNT; k++) begin
        hkind[k]  = H_DEFAULT;
        hreset[k] = 1'b0;
      end
      awaited_outcomes.delete();
    end else begin
      if (done) begin
        got = {status, popped_signal, pop_action, pending_set};
        if (awaited_outcomes.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result at %0t: status %0d signal %0d action %0d pending %h",
                     $time, got.status, got.sig, got.act, got.pset);
        end else begin
          want = awaited_outcomes.pop_front();
          checked_count++;
          if (want.act != ACT_NONE) acted_pop_count++;
          if (got.status !== want.status || got.sig !== want.sig ||
              got.act !== want.act || got.pset !== want.pset) begin
            error_count++;
            if (error_count <= 10)
              $display({"mismatch at %0t (expected/actual): status %0d/%0d signal %0d/%0d",
                        " action %0d/%0d pending %h/%h"}, $time, want.status, got.status,
                       want.sig, got.sig, want.act, got.act, want.pset, got.pset);
          end
        end
      end
      if (start && !busy) predict_command();
      if (psel && penable && pwrite && pready && paddr == INIT_ADDR) init_proc = pwdata[0];
    end
    awaited_count = awaited_outcomes.size();
  end

endmodule

`default_nettype wire

// ----- test/tb_signal_pending_controller_core.sv -----
`default_nettype none

module tb_signal_pending_controller_core;
  timeunit 1ns;
  timeprecision 1ps;
  import spc_pkg::*;

  // Register 0 sits at byte address 0
  localparam logic [2:0] INIT_ADDR      = {REG_IS_INIT, 2'b00};
  localparam logic [1:0] H_SPARE        = 2'd3;   // unused handler kind, stored as default
  localparam logic [2:0] OP_SPARE_LO    = 3'd5;
  localparam logic [2:0] OP_SPARE_HI    = 3'd7;
  localparam int         RANDOM_ITEMS   = 1500;
  localparam int         PHASES         = 4;
  // Longest pop walks all 64 signals; leave margin
  localparam int         SETTLE_CYCLES  = 140;
  localparam int         WATCHDOG_LIMIT = 2000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [2:0]           operation;
  logic [SIG_NUM_W-1:0] signal_number;
  logic                 to_group;
  logic [PEND_W-1:0]    new_blocked_mask;
  logic [1:0]           handler_kind;
  logic                 reset_on_delivery;
  logic                 done;
  logic                 status;
  logic [SIG_NUM_W-1:0] popped_signal;
  logic [2:0]           pop_action;
  logic [PEND_W-1:0]    pending_set;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  int error_count;
  int awaited_count;
  int checked_count;
  int acted_pop_count;
  int issued_count;
  int quiet_cycles;

  signal_pending_controller_core uut (.*);

  spc_outcome_checker #(.INIT_ADDR(INIT_ADDR)) outcome_check (.*);

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: count cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("signal_pending_controller_core test failed");
        $finish;
      end
    end
  end

  // Scramble the command fields while start is low so the block sees noise
  task automatic scramble_fields();
    operation         = 3'($urandom);
    signal_number     = SIG_NUM_W'($urandom);
    to_group          = 1'($urandom);
    new_blocked_mask  = {$urandom, $urandom};
    handler_kind      = 2'($urandom);
    reset_on_delivery = 1'($urandom);
  endtask

  // Present one command at the falling edge and hold it until the transfer.
  // Leave start high on return so a following command keeps it up.
  task automatic issue(input logic [2:0] op, input int unsigned sig, input logic grp,
                       input logic [PEND_W-1:0] mask, input logic [1:0] kind,
                       input logic rod);
    @(negedge clk);
    start             = 1'b1;
    operation         = op;
    signal_number     = SIG_NUM_W'(sig);
    to_group          = grp;
    new_blocked_mask  = mask;
    handler_kind      = kind;
    reset_on_delivery = rod;
    @(posedge clk);
    while (busy) @(posedge clk);
    issued_count++;
  endtask

  // Drop start for a burst of idle cycles
  task automatic idle_for(input int unsigned cycles);
    @(negedge clk);
    start = 1'b0;
    scramble_fields();
    paddr  = 3'($urandom);
    pwdata = $urandom;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Hold off until every predicted result has come back
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    scramble_fields();
    while (awaited_count != 0) @(negedge clk);
  endtask

  // Two-phase register write, issued only while the block is idle
  task automatic write_init(input logic value);
    drain();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = INIT_ADDR;
    pwdata  = ($urandom & ~32'd1) | 32'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'($urandom);
  endtask

  // Favor the job-control and ignore-by-default numbers, with some out of range
  function automatic int unsigned pick_signal();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(SIGNAL_COUNT + 1, 127);
    if (r < 9) begin
      case ($urandom_range(0, 9))
        0: return SIGKILL;
        1: return SIGCONT;
        2: return SIGSTOP;
        3: return SIGTSTP;
        4: return SIGTTIN;
        5: return SIGTTOU;
        6: return 17;
        7: return 23;
        8: return 28;
        default: return 10;
      endcase
    end
    return $urandom_range(1, SIGNAL_COUNT);
  endfunction

  // Sparse masks keep enough signals unblocked for pops to reach deep
  function automatic logic [PEND_W-1:0] pick_mask();
    logic [PEND_W-1:0] m;
    m = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       m = '0;
      1:       m = '1;
      2, 3:    m = m & {$urandom, $urandom} & {$urandom, $urandom};
      default: ;
    endcase
    return m;
  endfunction

  task automatic issue_random();
    int unsigned r;
    logic [2:0]  op;
    r = $urandom_range(0, 99);
    if (r < 38)      op = OP_SEND;
    else if (r < 60) op = OP_POP;
    else if (r < 67) op = OP_SET_BLOCKED;
    else if (r < 82) op = OP_SET_ACTION;
    else if (r < 95) op = OP_READ_PENDING;
    else             op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    issue(op, pick_signal(), 1'($urandom), pick_mask(), 2'($urandom), 1'($urandom));
  endtask

  initial begin
    int phase;
    int n;
    int gap_odds;

    // Hold every input at a known value through reset
    rst     = 1'b1;
    start   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    operation         = OP_SEND;
    signal_number     = '0;
    to_group          = 1'b0;
    new_blocked_mask  = '0;
    handler_kind      = H_DEFAULT;
    reset_on_delivery = 1'b0;
    gap_odds     = 0;
    issued_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, ordinary task first
    write_init(1'b0);
    issue(OP_SET_ACTION, 10, 1'b0, '0, H_CAUGHT, 1'b1);          // caught, one-shot
    issue(OP_SET_ACTION, SIGKILL, 1'b0, '0, H_CAUGHT, 1'b0);     // kill is fixed
    issue(OP_SET_ACTION, 0, 1'b0, '0, H_IGNORE, 1'b0);           // signal zero rejected
    issue(OP_SET_ACTION, 127, 1'b1, '1, H_SPARE, 1'b1);          // out of range
    issue(OP_SET_ACTION, 2, 1'b0, '0, H_SPARE, 1'b0);            // kind three kept as default
    issue(OP_SET_ACTION, SIGNAL_COUNT, 1'b0, '0, H_IGNORE, 1'b0);
    issue(OP_SEND, 0, 1'b1, '0, H_DEFAULT, 1'b0);                // existence probe
    issue(OP_SEND, 127, 1'b1, '1, H_DEFAULT, 1'b0);              // out of range
    issue(OP_SEND, SIGSTOP, 1'b0, '0, H_DEFAULT, 1'b0);
    issue(OP_SEND, SIGTSTP, 1'b1, '0, H_DEFAULT, 1'b0);
    issue(OP_SEND, SIGCONT, 1'b1, '0, H_DEFAULT, 1'b0);          // wipes the stop class
    issue(OP_SEND, SIGTTOU, 1'b0, '0, H_DEFAULT, 1'b0);          // wipes the continue
    issue(OP_SEND, 17, 1'b0, '0, H_DEFAULT, 1'b0);               // ignored by default
    issue(OP_SEND, 10, 1'b1, '0, H_DEFAULT, 1'b0);
    issue(OP_SEND, 1, 1'b0, '0, H_DEFAULT, 1'b0);
    issue(OP_SET_BLOCKED, 0, 1'b0, '1, H_DEFAULT, 1'b0);         // kill and stop stay open
    issue(OP_SEND, SIGNAL_COUNT, 1'b0, '0, H_DEFAULT, 1'b0);     // blocked, so it pends
    issue(OP_SEND, SIGKILL, 1'b0, '0, H_DEFAULT, 1'b0);
    issue(OP_READ_PENDING, 0, 1'b0, '0, H_DEFAULT, 1'b0);
    issue(OP_POP, 0, 1'b0, '0, H_DEFAULT, 1'b0);                 // kill terminates
    issue(OP_POP, 0, 1'b0, '0, H_DEFAULT, 1'b0);                 // nothing visible, so nothing reported
    issue(OP_SET_BLOCKED, 0, 1'b0, '0, H_DEFAULT, 1'b0);
    // pop the terminating one, the one-shot delivery, then the stop-class one
    repeat (3) issue(OP_POP, 0, 1'b0, '0, H_DEFAULT, 1'b0);
    issue(OP_SPARE_LO, SIGNAL_COUNT, 1'b1, '1, H_CAUGHT, 1'b1);
    issue(OP_SPARE_HI, 0, 1'b0, '0, H_DEFAULT, 1'b0);

    // Random phases alternate the init setting; the last runs without gaps
    for (phase = 0; phase < PHASES; phase++) begin
      write_init(phase % 2 == 0);
      for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (phase < PHASES - 1) begin
          // pick a fresh gap density every 50 commands, zero meaning a calm stretch
          if (n % 50 == 0) gap_odds = $urandom_range(0, 3);
          if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
            idle_for($urandom_range(1, 11));
        end
        // stall the sender once until the block has nothing in flight
        if (phase == 1 && n == RANDOM_ITEMS / PHASES / 2) drain();
        issue_random();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Ran %0d commands with init off and on, %0d results compared.",
             issued_count, checked_count);
    $display("Pops that acted on a signal: %0d.", acted_pop_count);
    if (error_count == 0 && awaited_count == 0) begin
      $display("signal_pending_controller_core test passed");
    end else begin
      $display("signal_pending_controller_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
